FILE: sv/mbe_pkg.sv
package mbe_pkg;

   localparam int COORD_FRAC_BITS = 28;
   localparam int ITER_BITS = 12;
   localparam int PIXEL_BITS = 12;

   localparam int CFG_IDX_BITS = 3;
   localparam int CFG_DATA_BITS = 32;

   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_VIEW_X_MIN    = 3'd2;
   localparam logic [2:0] REG_VIEW_Y_MIN    = 3'd3;
   localparam logic [2:0] REG_VIEW_WIDTH    = 3'd4;
   localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd5;
   localparam logic [2:0] REG_ITER_MAX      = 3'd6;
   localparam logic [2:0] REG_COLOR_MODE    = 3'd7;

   localparam logic [1:0] MODE_POLY   = 2'd0;
   localparam logic [1:0] MODE_PACKED = 2'd1;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [31:0] view_x_min;
      logic [31:0] view_y_min;
      logic [30:0] view_width;
      logic [30:0] view_height;
      logic [11:0] iter_max;
      logic [1:0]  color_mode;
   } cfg_type;

endpackage

FILE: sv/mbe_if.sv
interface mbe_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [11:0] iteration_count;
   modport source (output valid, red, green, blue, iteration_count, input ready);
   modport sink (input valid, red, green, blue, iteration_count, output ready);
endinterface

FILE: sv/mbe_divider.sv
// Restoring divider: one quotient bit per cycle.
module mbe_divider #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] denominator,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_BITS-1:0], quo_ff[NUM_BITS-1]};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: sv/mbe_multiplier.sv
// Registered 34x34 unsigned multiplier.
module mbe_multiplier (
   input  logic        clock,
   input  logic [33:0] op_a,
   input  logic [33:0] op_b,
   output logic [67:0] product
);
   logic [67:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule

FILE: sv/mandelbrot_escape_pixel_color.sv
// Channel | Dir | Handshake    | Payload
// req     | in  | valid/ready  | pixel_x, pixel_y
// rsp     | out | valid/ready  | red, green, blue, iteration_count
// csr     | in  | write enable | index 0..7, 32-bit data
//
// One request at a time. Mapping takes two serial divides; every escape iteration runs
// on the one shared multiplier through test, zx*zy, update, zx^2 and zy^2 (over two steps);
// colour takes a divide (skipped at a zero limit) plus the multiplier passes of its mode.
// Reset is synchronous; it clears control state and loads the default configuration.
// A finished result holds in the output register until taken; req ready is low meanwhile.
module mandelbrot_escape_pixel_color (
   input  logic                              clock,
   input  logic                              reset,
   mbe_req_if.sink                           req,
   mbe_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic [mbe_pkg::CFG_IDX_BITS-1:0]  csr_index,
   input  logic [mbe_pkg::CFG_DATA_BITS-1:0] csr_data
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MAPX  = 4'd1;
   localparam logic [3:0] ST_MAPY  = 4'd2;
   localparam logic [3:0] ST_TEST  = 4'd3;
   localparam logic [3:0] ST_MXY   = 4'd4;
   localparam logic [3:0] ST_MXX   = 4'd5;
   localparam logic [3:0] ST_MYY   = 4'd6;
   localparam logic [3:0] ST_SQ    = 4'd7;
   localparam logic [3:0] ST_TDIV  = 4'd8;
   localparam logic [3:0] ST_COL   = 4'd9;
   localparam logic [3:0] ST_HDIV  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   localparam int NUM_BITS = 48;
   localparam logic [63:0] LIM = 64'd4 << mbe_pkg::COORD_FRAC_BITS;
   localparam logic [63:0] CAP = 64'd1 << 60;

   // palette gains and the hue ramp scale
   localparam logic [33:0] RED_GAIN   = 34'd2295;
   localparam logic [33:0] GREEN_GAIN = 34'd3825;
   localparam logic [33:0] BLUE_GAIN  = 34'd4335;
   localparam logic [33:0] HUE_SCALE  = 34'd25;
   // ceil(2^24 / 6): exact floor division by six for numerators below 2^23
   localparam logic [33:0] RECIP_SIX  = 34'd2796203;

   mbe_pkg::cfg_type cfg_ff, cfg_in;
   logic [3:0]  state_ff, state_in;
   logic [mbe_pkg::PIXEL_BITS-1:0] px_ff, py_ff;
   logic signed [63:0] cx_ff, cy_ff, zx_ff, zy_ff, zx_in, zy_in;
   logic [63:0] zx2_ff, zy2_ff, zx2_in, zy2_in;
   logic [mbe_pkg::ITER_BITS-1:0] n_ff, n_in;
   logic [16:0] t_ff, t_in;
   logic [3:0]  step_ff, step_in;
   logic [63:0] acc_ff, acc_in, acc2_ff, acc2_in;
   logic [7:0]  r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic        go_ff, go_in;

   // shared multiplier
   logic [33:0] ma, mb;
   logic [67:0] mprod;
   mbe_multiplier u_mul (.clock(clock), .op_a(ma), .op_b(mb), .product(mprod));

   // shared divider
   logic                div_start, div_done;
   logic [NUM_BITS-1:0] div_num, div_q;
   logic [12:0]         div_den;
   mbe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(13)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_q));

   function automatic logic [63:0] mag(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   // truncate and cap a fixed-point product of magnitudes below 2^34
   function automatic logic [63:0] fx(input logic [67:0] p);
      logic [67:0] s;
      s = p >> mbe_pkg::COORD_FRAC_BITS;
      return (s > 68'(CAP)) ? CAP : s[63:0];
   endfunction

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [7:0] sat8(input logic [35:0] v);
      return (v > 36'd255) ? 8'd255 : v[7:0];
   endfunction

   logic [12:0] den_w, den_h;
   logic        sgn;
   logic [63:0] m1, m2, fxp;
   logic [16:0] u;
   logic [18:0] hue;
   logic [23:0] rise_full, fall_full;

   assign den_w = (cfg_ff.screen_width == '0) ? 13'd1 : cfg_ff.screen_width;
   assign den_h = (cfg_ff.screen_height == '0) ? 13'd1 : cfg_ff.screen_height;
   assign u = 17'd65536 - t_ff;
   assign fxp = fx(mprod);
   // hue position in Q.16: sector above bit 16, fraction below
   assign hue = mprod[42:24];
   assign rise_full = {hue[15:0], 8'd0} - {8'd0, hue[15:0]};
   assign fall_full = 24'hFF0000 - rise_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mbe_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[12:0];
            mbe_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[12:0];
            mbe_pkg::REG_VIEW_X_MIN:    cfg_in.view_x_min    = csr_data;
            mbe_pkg::REG_VIEW_Y_MIN:    cfg_in.view_y_min    = csr_data;
            mbe_pkg::REG_VIEW_WIDTH:    cfg_in.view_width    = csr_data[30:0];
            mbe_pkg::REG_VIEW_HEIGHT:   cfg_in.view_height   = csr_data[30:0];
            mbe_pkg::REG_ITER_MAX:      cfg_in.iter_max      = csr_data[11:0];
            mbe_pkg::REG_COLOR_MODE:    cfg_in.color_mode    = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      zx_in = zx_ff; zy_in = zy_ff; zx2_in = zx2_ff; zy2_in = zy2_ff;
      n_in = n_ff; t_in = t_ff; step_in = step_ff; acc_in = acc_ff; acc2_in = acc2_ff;
      r_in = r_ff; g_in = g_ff; b_in = b_ff;
      go_in = 1'b0;
      div_start = 1'b0;
      div_num = '0;
      div_den = 13'd1;
      ma = '0; mb = '0;
      sgn = 1'b0; m1 = '0; m2 = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_MAPX;
               go_in = 1'b1;
            end
         end
         ST_MAPX: begin
            // kick the x divide, then wait for it
            div_start = go_ff;
            div_num = NUM_BITS'(px_ff) * NUM_BITS'(cfg_ff.view_width);
            div_den = den_w;
            if (div_done) begin
               state_in = ST_MAPY;
               go_in = 1'b1;
            end
         end
         ST_MAPY: begin
            div_start = go_ff;
            div_num = NUM_BITS'(py_ff) * NUM_BITS'(cfg_ff.view_height);
            div_den = den_h;
            if (div_done) begin
               state_in = ST_TEST;
               step_in = '0;
               zx_in = '0; zy_in = '0; zx2_in = '0; zy2_in = '0; n_in = '0;
            end
         end
         ST_TEST: begin
            if (n_ff < cfg_ff.iter_max && (zx2_ff + zy2_ff) < LIM) begin
               state_in = ST_MXY;
            end else begin
               state_in = ST_TDIV;
               go_in = 1'b1;
            end
         end
         ST_MXY: begin
            // both magnitudes are below 2.0 while the loop runs
            m1 = mag(zx_ff); m2 = mag(zy_ff);
            ma = m1[33:0]; mb = m2[33:0];
            state_in = ST_MXX;
         end
         ST_MXX: begin
            sgn = zx_ff[63] ^ zy_ff[63];
            zy_in = 64'sd2 * (sgn ? -$signed(fxp) : $signed(fxp)) + cy_ff;
            zx_in = $signed(zx2_ff) - $signed(zy2_ff) + cx_ff;
            state_in = ST_MYY;
         end
         ST_MYY: begin
            m1 = mag(zx_ff);
            ma = m1[33:0]; mb = m1[33:0];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            m2 = mag(zy_ff);
            if (step_ff == 4'd0) begin
               zx2_in = (fxp > LIM) ? LIM : fxp;
               ma = m2[33:0]; mb = m2[33:0];
               n_in = n_ff + 1'b1;
               step_in = 4'd1;
            end else begin
               // a huge zy squares far past the bound: clamp without the multiplier
               zy2_in = (|m2[63:34] || fxp > LIM) ? LIM : fxp;
               step_in = 4'd0;
               state_in = ST_TEST;
            end
         end
         ST_TDIV: begin
            div_start = go_ff && (cfg_ff.iter_max != '0);
            div_num = NUM_BITS'({n_ff, 16'd0});
            div_den = {1'b0, cfg_ff.iter_max};
            if (cfg_ff.iter_max == '0) begin
               t_in = '0;
               state_in = ST_COL;
               step_in = '0;
            end else if (div_done) begin
               t_in = div_q[16:0];
               state_in = ST_COL;
               step_in = '0;
            end
         end
         ST_COL: begin
            case (cfg_ff.color_mode)
               mbe_pkg::MODE_POLY: begin
                  // one multiplier pass a cycle; each product lands in the next cycle
                  step_in = step_ff + 4'd1;
                  case (step_ff)
                     4'd0: begin ma = 34'(u); mb = 34'(t_ff); end
                     4'd1: begin
                        acc_in = mprod[63:0];
                        ma = 34'(t_ff); mb = 34'(t_ff);
                     end
                     4'd2: begin
                        // red: (u*t) * (t*t)
                        acc2_in = mprod[63:0];
                        ma = acc_ff[33:0]; mb = mprod[33:0];
                     end
                     4'd3: begin ma = 34'(mprod[63:32]); mb = RED_GAIN; end
                     4'd4: begin
                        r_in = sat8(mprod[67:32]);
                        ma = 34'(u); mb = 34'(u);
                     end
                     4'd5: begin
                        // green: (u*u) * (t*t); keep u*u for blue
                        acc2_in = mprod[63:0];
                        ma = mprod[33:0]; mb = acc2_ff[33:0];
                     end
                     4'd6: begin ma = 34'(mprod[63:32]); mb = GREEN_GAIN; end
                     4'd7: begin
                        // blue: (u*u) * (u*t)
                        g_in = sat8(mprod[67:32]);
                        ma = acc2_ff[33:0]; mb = acc_ff[33:0];
                     end
                     4'd8: begin ma = 34'(mprod[63:32]); mb = BLUE_GAIN; end
                     4'd9: begin
                        b_in = sat8(36'(mprod[67:33]));
                        step_in = '0;
                        state_in = ST_OUT;
                     end
                     default: begin
                        step_in = '0;
                        state_in = ST_OUT;
                     end
                  endcase
               end
               mbe_pkg::MODE_PACKED: begin
                  b_in = t_ff[16] ? 8'd0 : t_ff[15:8];
                  r_in = t_ff[7:0];
                  g_in = 8'd0;
                  state_in = ST_OUT;
               end
               default: begin
                  ma = 34'(t_ff); mb = HUE_SCALE;
                  step_in = '0;
                  state_in = ST_HDIV;
               end
            endcase
         end
         ST_HDIV: begin
            if (step_ff == 4'd0) begin
               // divide 25*t by six through the reciprocal
               ma = mprod[33:0]; mb = RECIP_SIX;
               step_in = 4'd1;
            end else begin
               case (hue[18:16])
                  3'd0: begin r_in = 8'd255; g_in = rise_full[23:16]; b_in = 8'd0; end
                  3'd1: begin r_in = fall_full[23:16]; g_in = 8'd255; b_in = 8'd0; end
                  3'd2: begin r_in = 8'd0; g_in = 8'd255; b_in = rise_full[23:16]; end
                  3'd3: begin r_in = 8'd0; g_in = fall_full[23:16]; b_in = 8'd255; end
                  3'd4: begin r_in = rise_full[23:16]; g_in = 8'd0; b_in = 8'd255; end
                  default: begin r_in = 8'd255; g_in = 8'd0; b_in = fall_full[23:16]; end
               endcase
               step_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         px_ff <= req.pixel_x;
         py_ff <= req.pixel_y;
      end
      if (state_ff == ST_MAPX && div_done)
         cx_ff <= sat32($signed(cfg_ff.view_x_min) + $signed({16'd0, div_q}));
      if (state_ff == ST_MAPY && div_done)
         cy_ff <= sat32($signed(cfg_ff.view_y_min) + $signed({16'd0, div_q}));
      zx_ff <= zx_in; zy_ff <= zy_in; zx2_ff <= zx2_in; zy2_ff <= zy2_in;
      n_ff <= n_in; t_ff <= t_in; acc_ff <= acc_in; acc2_ff <= acc2_in;
      r_ff <= r_in; g_ff <= g_in; b_ff <= b_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         go_ff    <= 1'b0;
         cfg_ff.screen_width  <= 13'd640;
         cfg_ff.screen_height <= 13'd480;
         cfg_ff.view_x_min    <= -32'sd536870912;
         cfg_ff.view_y_min    <= -32'sd402653184;
         cfg_ff.view_width    <= 31'd805306368;
         cfg_ff.view_height   <= 31'd805306368;
         cfg_ff.iter_max      <= 12'd255;
         cfg_ff.color_mode    <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         go_ff    <= go_in;
         cfg_ff   <= cfg_in;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.red = r_ff;
   assign rsp.green = g_ff;
   assign rsp.blue = b_ff;
   assign rsp.iteration_count = n_ff;

   // hold the result while the sink stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.iteration_count))
      else $error("result dropped while stalled");
   // no new request while busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("ready raised while busy");
   // count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (n_ff <= cfg_ff.iter_max))
      else $error("iteration count beyond limit");
endmodule
